### src/csr_sparse_matrix_vector_mac_defines.svh
// Assertion macros for the CSR sparse matrix-vector block.
// Used by csrmv_acc; needs a clk and an rst in scope.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MAC_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MAC_DEFINES_SVH

`ifndef SYNTHESIS
`define CSRMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSRMV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSRMV_ASSERT(lbl, prop, msg)
`define CSRMV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/csrmv_pkg.sv
// Shared constants, codes and stage types of the CSR sparse matrix-vector block.
// No dependencies; the other files that use it refer to it by scoped names.
package csrmv_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int VALUE_BITS   = 32;

  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 12;
  localparam int OPERAND_W  = 32;
  localparam int ROW_W      = 16;
  localparam int ACC_W      = 48;
  localparam int FRAC_SHIFT = 24;
  localparam int ADDR_W     = $clog2(VECTOR_DEPTH);
  localparam int PROD_W     = 2 * VALUE_BITS;
  localparam int SUM_W      = ACC_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_NZ   = 2'd1,
    MODE_END  = 2'd2
  } mode_t;

  typedef struct packed {
    logic                     valid;
    logic                     is_nz;
    logic                     is_end;
    logic signed [PROD_W-1:0] product;
  } stage_t;

endpackage

### src/csrmv_item_if.sv
// Request channel carrying one input item: mode, index and operand.
// Depends on csrmv_pkg for field widths.
interface csrmv_item_if;
  logic                                      valid;
  logic                                      ready;
  logic [csrmv_pkg::MODE_W-1:0]              mode;
  logic [csrmv_pkg::INDEX_W-1:0]             index;
  logic signed [csrmv_pkg::OPERAND_W-1:0]    operand;

  modport source (output valid, output mode, output index, output operand, input ready);
  modport sink   (input valid, input mode, input index, input operand, output ready);
endinterface

### src/csrmv_result_if.sv
// Result channel carrying one finished row: number, sum and clip flag.
// Depends on csrmv_pkg for field widths.
interface csrmv_result_if;
  logic                               valid;
  logic                               ready;
  logic [csrmv_pkg::ROW_W-1:0]        row_number;
  logic signed [csrmv_pkg::ACC_W-1:0] row_sum;
  logic                               saturated;

  modport source (output valid, output row_number, output row_sum, output saturated,
                  input ready);
  modport sink   (input valid, input row_number, input row_sum, input saturated,
                  output ready);
endinterface

### src/csrmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/csrmv_acc.sv
// Row accumulator: floor shift, saturating add, row counter and result register.
// Depends on csrmv_pkg, csrmv_result_if and the assertion macro header.
`include "csr_sparse_matrix_vector_mac_defines.svh"

module csrmv_acc (
  input  logic                  clk,
  input  logic                  rst,
  input  csrmv_pkg::stage_t     s2,
  input  logic                  adv,
  output logic                  hold,
  csrmv_result_if.source        result
);

  logic signed [csrmv_pkg::ACC_W-1:0]  acc;
  logic                                clip_flag;
  logic [csrmv_pkg::ROW_W-1:0]         row_counter;
  logic                                res_valid;
  logic [csrmv_pkg::ROW_W-1:0]         res_row;
  logic signed [csrmv_pkg::ACC_W-1:0]  res_sum;
  logic                                res_sat;

  logic signed [csrmv_pkg::PROD_W-1:0] shifted;
  logic signed [csrmv_pkg::SUM_W-1:0]  addend;
  logic signed [csrmv_pkg::SUM_W-1:0]  sum_wide;
  logic signed [csrmv_pkg::ACC_W-1:0]  acc_next;
  logic                                clip_now;
  logic                                do_nz;
  logic                                do_end;

  always_comb begin
    shifted  = s2.product >>> csrmv_pkg::FRAC_SHIFT;
    addend   = csrmv_pkg::SUM_W'(shifted);
    sum_wide = csrmv_pkg::SUM_W'(acc) + addend;
    clip_now = 1'b0;
    if (sum_wide > csrmv_pkg::SUM_HI) begin
      acc_next = csrmv_pkg::ACC_W'(csrmv_pkg::SUM_HI);
      clip_now = 1'b1;
    end else if (sum_wide < csrmv_pkg::SUM_LO) begin
      acc_next = csrmv_pkg::ACC_W'(csrmv_pkg::SUM_LO);
      clip_now = 1'b1;
    end else begin
      acc_next = csrmv_pkg::ACC_W'(sum_wide);
    end
  end

  assign hold   = s2.valid && s2.is_end && res_valid && !result.ready;
  assign do_nz  = adv && s2.valid && s2.is_nz;
  assign do_end = adv && s2.valid && s2.is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      clip_flag   <= 1'b0;
      row_counter <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (do_end) begin
        acc         <= '0;
        clip_flag   <= 1'b0;
        row_counter <= row_counter + 1'b1;
        res_valid   <= 1'b1;
      end else begin
        if (do_nz) begin
          acc       <= acc_next;
          clip_flag <= clip_flag | clip_now;
        end
        if (result.ready) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      res_row <= row_counter;
      res_sum <= acc;
      res_sat <= clip_flag;
    end
  end

  assign result.valid      = res_valid;
  assign result.row_number = res_row;
  assign result.row_sum    = res_sum;
  assign result.saturated  = res_sat;

  `CSRMV_ASSERT(a_clear_after_emit, do_end |=> (acc == '0 && !clip_flag), "row state not cleared after emit")
  `CSRMV_ASSERT(a_row_advance, do_end |=> (row_counter == csrmv_pkg::ROW_W'($past(row_counter) + 1'b1)), "row counter did not advance")
  `CSRMV_ASSERT(a_flag_quiet, (do_nz && !clip_flag && !clip_now) |=> !clip_flag, "clip flag set without a clip")
  `CSRMV_ASSERT_ALWAYS(a_hold_needs_full, hold |-> res_valid, "stall with an empty result register")

endmodule

### src/csr_sparse_matrix_vector_mac.sv
// CSR sparse matrix times dense vector: one item per cycle, three stages deep
// (vector store read, multiply, floor shift with saturating accumulate). Load
// items write the vector store; nonzero items read it and add value * word to
// the row sum; end-of-row items pass through both stage registers and then emit
// row number, sum and clip flag into a result register. The single store read
// port and the accumulate register set the rate at one item per cycle; the input
// stalls only when an end-of-row item meets a result that has not yet been taken.
// Depends on csrmv_pkg, the two channel interfaces, csrmv_ram and csrmv_acc.
module csr_sparse_matrix_vector_mac (
  input  logic           clk,
  input  logic           rst,
  csrmv_item_if.sink     item,
  csrmv_result_if.source result
);

  logic                                    adv;
  logic                                    hold;
  logic                                    accept;
  logic                                    in_range;
  logic                                    is_load;
  logic                                    is_nz;
  logic                                    is_end;
  logic [csrmv_pkg::ADDR_W-1:0]            addr;
  logic [csrmv_pkg::VALUE_BITS-1:0]        rdata;

  logic                                    s1_valid;
  logic                                    s1_nz;
  logic                                    s1_end;
  logic                                    s1_hit;
  logic signed [csrmv_pkg::VALUE_BITS-1:0] s1_value;
  logic signed [csrmv_pkg::VALUE_BITS-1:0] word;
  logic signed [csrmv_pkg::PROD_W-1:0]     product;
  csrmv_pkg::stage_t                       s2;

  assign adv        = !hold;
  assign item.ready = adv;
  assign accept     = item.valid && adv;
  assign is_load    = item.mode == csrmv_pkg::MODE_LOAD;
  assign is_nz      = item.mode == csrmv_pkg::MODE_NZ;
  assign is_end     = item.mode == csrmv_pkg::MODE_END;
  assign in_range   = 32'(item.index) < 32'(csrmv_pkg::VECTOR_DEPTH);
  assign addr       = csrmv_pkg::ADDR_W'(item.index);

  csrmv_ram #(
    .WIDTH (csrmv_pkg::VALUE_BITS),
    .DEPTH (csrmv_pkg::VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && is_load && in_range),
    .waddr (addr),
    .wdata (item.operand[csrmv_pkg::VALUE_BITS-1:0]),
    .re    (accept && is_nz),
    .raddr (addr),
    .rdata (rdata)
  );

  // drop the out-of-range column: it adds nothing
  assign word    = s1_hit ? $signed(rdata) : '0;
  assign product = s1_value * word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && (is_nz || is_end);
      s2.valid <= s1_valid;
    end
    if (adv) begin
      s1_nz      <= is_nz;
      s1_end     <= is_end;
      s1_hit     <= in_range;
      s1_value   <= item.operand[csrmv_pkg::VALUE_BITS-1:0];
      s2.is_nz   <= s1_nz;
      s2.is_end  <= s1_end;
      s2.product <= product;
    end
  end

  csrmv_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .s2     (s2),
    .adv    (adv),
    .hold   (hold),
    .result (result)
  );

endmodule
